/* sv/block_stack_scan_matcher_assert.svh */
// Assertion macros for the block stack scan matcher.
`ifndef BLOCK_STACK_SCAN_MATCHER_ASSERT_SVH
`define BLOCK_STACK_SCAN_MATCHER_ASSERT_SVH

// Asserts that a condition implies another on the same edge.
`define BSSM_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("bssm check failed");

// Asserts that a condition implies another on the next edge.
`define BSSM_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("bssm check failed");

`endif

/* sv/bssm_pkg.sv */
package bssm_pkg;
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_BYTE   = 3'd3;
  localparam logic [2:0] OP_RDBLK  = 3'd4;
  localparam logic [2:0] OP_RDHGT  = 3'd5;

  localparam logic [1:0] LED_NONE  = 2'd0;
  localparam logic [1:0] LED_RED   = 2'd1;
  localparam logic [1:0] LED_GREEN = 2'd2;

  localparam logic [1:0] MODE_MATCH = 2'd0;
  localparam logic [1:0] MODE_GREEN = 2'd1;
  localparam logic [1:0] MODE_RED   = 2'd2;

  localparam logic [7:0] ID_MASK  = 8'hFC;
  localparam logic [7:0] ROT_MASK = 8'h03;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] tile;
    logic [3:0] level;
    logic [7:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0] tx_byte;
    logic [7:0] read_value;
    logic [4:0] stack_height;
    logic       tile_done;
    logic       scan_done;
    logic [4:0] current_tile;
    logic       complete;
    logic       corrupted;
  } out_word_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [2:0] opcode;
    logic       in_range;
    logic       tile_ok;
    logic [3:0] tile;
    logic [3:0] level;
    logic [7:0] data_in;
  } cmd_t;
endpackage

/* sv/bssm_if.sv */
interface bssm_in_if;
  import bssm_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bssm_out_if;
  import bssm_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bssm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/bssm_ram.sv */
module bssm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/bssm_front.sv */
module bssm_front #(
  parameter int TILE_COUNT = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  bssm_in_if.sink        in_ch,
  output logic           q_valid,
  output bssm_pkg::cmd_t q_cmd,
  input  logic           q_ready
);
  import bssm_pkg::*;

  // Two-entry queue of classified commands.
  cmd_t       buf_r [2];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       cmd;
  logic       push, pop;

  always_comb begin
    cmd.opcode   = in_ch.payload.opcode;
    cmd.tile     = in_ch.payload.tile;
    cmd.level    = in_ch.payload.level;
    cmd.data_in  = in_ch.payload.data_in;
    cmd.tile_ok  = {3'b0, in_ch.payload.tile} < 7'(TILE_COUNT);
    cmd.in_range = cmd.tile_ok && ({3'b0, in_ch.payload.level} < 7'(MAX_HEIGHT));
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push  = in_ch.valid && in_ch.ready;
  assign pop   = q_valid && q_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= cmd;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

/* sv/bssm_back.sv */
module bssm_back #(
  parameter int TILE_COUNT = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  bssm_pkg::cmd_t q_cmd,
  output logic           q_ready,
  input  logic [1:0]     lamp_sel,
  bssm_out_if.source     out_ch,
  output logic           busy
);
  import bssm_pkg::*;

  localparam int TW = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
  localparam int LW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = TW + LW;
  localparam int DEPTH = 1 << AW;
  localparam int CW = $clog2(TILE_COUNT + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_EXEC, S_CLEAR, S_OUT} state_t;
  state_t state_r;

  cmd_t            cmd_r;
  logic [CW-1:0]   tile_r;
  logic [HW-1:0]   level_r;
  logic [1:0]      rot_r, led_r;
  logic            complete_r, corrupted_r, scanning_r;
  logic [AW-1:0]   clr_r;
  logic [HW-1:0]   hgt_r [TILE_COUNT];
  logic [7:0]      rd_val_r;
  logic [4:0]      hgt_out_r;
  logic            tdone_r, sdone_r;
  out_word_t       out_word;

  logic [AW-1:0]   cmd_addr, scan_addr, raddr_tg, raddr_sc, waddr_tg, waddr_sc;
  logic [7:0]      t_rdata, s_rdata, t_wdata, s_wdata, absb, mask;
  logic            t_we, s_we;
  logic [1:0]      rot;
  logic            ok;

  assign cmd_addr = {TW'(q_cmd.tile), LW'(q_cmd.level)};
  assign scan_addr = {TW'(tile_r), LW'(level_r)};
  // Reads are issued while the command is taken so data arrives in S_EXEC.
  assign raddr_tg = (q_cmd.opcode == OP_BYTE) ? scan_addr : cmd_addr;
  assign raddr_sc = cmd_addr;

  assign rot  = cmd_r.data_in[1:0] + rot_r;
  assign absb = (cmd_r.data_in & ID_MASK) | {6'd0, rot};
  assign mask = ID_MASK | {6'd0, cmd_r.data_in[3:2]};
  assign ok   = (absb & mask) == (t_rdata & mask);

  always_comb begin
    t_we = 1'b0;
    waddr_tg = {TW'(cmd_r.tile), LW'(cmd_r.level)};
    t_wdata = cmd_r.data_in;
    if (state_r == S_CLEAR || state_r == S_INIT) begin
      t_we = 1'b1;
      waddr_tg = clr_r;
      t_wdata = '0;
    end else if (state_r == S_EXEC && cmd_r.opcode == OP_WRITE && cmd_r.in_range) begin
      t_we = 1'b1;
    end
  end

  // After reset both tables are zeroed by the same walk that a clear uses.
  always_comb begin
    s_we = (state_r == S_EXEC) && (cmd_r.opcode == OP_BYTE) && scanning_r
           && (level_r < HW'(MAX_HEIGHT)) && (cmd_r.data_in != 8'd0);
    waddr_sc = scan_addr;
    s_wdata = absb;
    if (state_r == S_INIT) begin
      s_we = 1'b1;
      waddr_sc = clr_r;
      s_wdata = '0;
    end
  end

  bssm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_target (
    .clk(clk), .we(t_we), .waddr(waddr_tg), .wdata(t_wdata),
    .raddr(raddr_tg), .rdata(t_rdata)
  );

  bssm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_scanned (
    .clk(clk), .we(s_we), .waddr(waddr_sc), .wdata(s_wdata),
    .raddr(raddr_sc), .rdata(s_rdata)
  );

  assign q_ready = (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.payload = out_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      tile_r <= '0;
      level_r <= '0;
      rot_r <= '0;
      led_r <= '0;
      complete_r <= 1'b0;
      corrupted_r <= 1'b0;
      scanning_r <= 1'b0;
      foreach (hgt_r[i]) hgt_r[i] <= '0;
      clr_r <= '0;
    end else begin
      unique case (state_r)
        S_INIT: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          rd_val_r <= '0;
          hgt_out_r <= '0;
          tdone_r <= 1'b0;
          sdone_r <= 1'b0;
          state_r <= S_OUT;
          unique case (cmd_r.opcode)
            OP_CLEAR: begin
              clr_r <= '0;
              state_r <= S_CLEAR;
            end
            OP_START: begin
              complete_r <= 1'b1;
              corrupted_r <= 1'b0;
              scanning_r <= 1'b1;
              tile_r <= '0;
              level_r <= '0;
              rot_r <= '0;
              led_r <= LED_NONE;
            end
            OP_BYTE: begin
              if (scanning_r) begin
                if (level_r >= HW'(MAX_HEIGHT) || cmd_r.data_in == 8'd0) begin
                  tdone_r <= 1'b1;
                  level_r <= '0;
                  rot_r <= '0;
                  led_r <= LED_NONE;
                  tile_r <= tile_r + 1'b1;
                  if (tile_r == CW'(TILE_COUNT - 1)) begin
                    sdone_r <= 1'b1;
                    scanning_r <= 1'b0;
                  end
                  if (level_r >= HW'(MAX_HEIGHT) && cmd_r.data_in != 8'd0) begin
                    hgt_r[TW'(tile_r)] <= '0;
                    hgt_out_r <= '0;
                    complete_r <= 1'b0;
                    corrupted_r <= 1'b1;
                  end else begin
                    hgt_r[TW'(tile_r)] <= level_r;
                    hgt_out_r <= 5'(level_r);
                    if (level_r < HW'(MAX_HEIGHT) && t_rdata != 8'd0) complete_r <= 1'b0;
                  end
                end else begin
                  rot_r <= rot;
                  if (!ok) complete_r <= 1'b0;
                  case (lamp_sel)
                    MODE_MATCH: led_r <= ok ? LED_GREEN : LED_RED;
                    MODE_GREEN: led_r <= LED_GREEN;
                    MODE_RED:   led_r <= LED_RED;
                    default:    led_r <= LED_NONE;
                  endcase
                  level_r <= level_r + 1'b1;
                end
              end
            end
            OP_RDBLK: begin
              if (cmd_r.in_range)
                rd_val_r <= s_rdata;
            end
            OP_RDHGT: begin
              if (cmd_r.tile_ok)
                hgt_out_r <= 5'(hgt_r[TW'(cmd_r.tile)]);
            end
            default: ;
          endcase
        end
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(DEPTH - 1)) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    out_word.tx_byte = led_r;
    out_word.read_value = rd_val_r;
    out_word.stack_height = hgt_out_r;
    out_word.tile_done = tdone_r;
    out_word.scan_done = sdone_r;
    out_word.current_tile = 5'(tile_r);
    out_word.complete = complete_r;
    out_word.corrupted = corrupted_r;
  end
endmodule

/* sv/block_stack_scan_matcher.sv */
// Block stack scan matcher. Each input word is an opcode with a tile, a level
// and a data byte, and produces exactly one result word. A front stage takes
// words into a two-entry queue; the back stage runs one word at a time. A
// table read, write or scanned byte passes through the back stage in order:
// take, execute with registered memory read, present result. Clearing the
// target table walks every entry of the table memory, one entry per cycle.
// After reset the back stage zeroes both tables the same way before it takes
// the first word; the front queue holds up to two words meanwhile.
// The LED selection register must be written only while idle.
module block_stack_scan_matcher #(
  parameter int TILE_COUNT = 16,
  parameter int MAX_HEIGHT = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  bssm_in_if.sink    in_ch,
  bssm_out_if.source out_ch,
  bssm_cfg_if.sink   cfg_ch
);
  import bssm_pkg::*;

  logic       q_valid, q_ready, busy;
  cmd_t       q_cmd;
  logic [1:0] lamp_sel_r;

  // Configuration is always accepted.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lamp_sel_r <= MODE_MATCH;
    end else if (cfg_ch.valid) begin
      lamp_sel_r <= cfg_ch.data;
    end
  end

  bssm_front #(.TILE_COUNT(TILE_COUNT), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_ready(q_ready)
  );

  bssm_back #(.TILE_COUNT(TILE_COUNT), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd),
    .q_ready(q_ready), .lamp_sel(lamp_sel_r), .out_ch(out_ch), .busy(busy)
  );

`include "block_stack_scan_matcher_assert.svh"

  // A result is only offered while the back stage is holding a word.
  `BSSM_ASSERT_IMPL(a_out_busy, clk, rst_n, out_ch.valid, busy)
  // The back stage only takes a word from the queue while it is idle.
  `BSSM_ASSERT_IMPL(a_q_take, clk, rst_n, q_valid && q_ready, !busy)
  // A delivered result frees the back stage on the next edge.
  `BSSM_ASSERT_NEXT(a_out_free, clk, rst_n, out_ch.valid && out_ch.ready, !out_ch.valid)
endmodule

/* dv/block_stack_scan_matcher_tb.sv */
module block_stack_scan_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bssm_pkg::*;

  localparam int TILES = 16;
  localparam int MAXH = 16;
  // Cycles with no accepted word and no delivered result before the run is
  // declared hung.
  localparam int HANG_LIMIT = 20000;

  logic clk;
  logic rst_n;

  bssm_in_if  in_ch ();
  bssm_out_if out_ch ();
  bssm_cfg_if cfg_ch ();

  block_stack_scan_matcher dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the block's tables, scan state and LED mode.
  logic [7:0] tgt_tab [TILES*MAXH];
  logic [7:0] scan_tab [TILES*MAXH];
  logic [4:0] hgt_tab [TILES];
  int         cur_tile;
  int         cur_level;
  logic [1:0] rot_acc;
  logic [1:0] led_now;
  logic       f_complete;
  logic       f_corrupt;
  logic       f_scanning;
  logic [1:0] mode_shadow;

  in_word_t  pending_words [$];
  out_word_t expected_results [$];

  int  n_fail;
  int  n_sent;
  int  n_seen;
  int  hang_count;
  bit  long_stall_req;
  int  stall_left;
  int  scans_done;

  function automatic logic [1:0] led_for(logic ok);
    case (mode_shadow)
      MODE_MATCH: led_for = ok ? LED_GREEN : LED_RED;
      MODE_GREEN: led_for = LED_GREEN;
      MODE_RED:   led_for = LED_RED;
      default:    led_for = LED_NONE;
    endcase
  endfunction

  // Ends the tile being scanned with the given height.
  task automatic close_tile(input int h, inout out_word_t r);
    hgt_tab[cur_tile] = h[4:0];
    r.stack_height = h[4:0];
    r.tile_done = 1'b1;
    cur_level = 0;
    rot_acc = 2'd0;
    led_now = LED_NONE;
    cur_tile++;
    if (cur_tile >= TILES) begin
      r.scan_done = 1'b1;
      f_scanning = 1'b0;
      scans_done++;
    end
  endtask

  // Applies one accepted word to the shadow state and queues its result.
  task automatic predict_result(input in_word_t w);
    out_word_t r;
    int idx;
    logic [1:0] rot;
    logic [7:0] msk;
    logic [7:0] absb;
    logic ok;
    r = '0;
    case (w.opcode)
      OP_CLEAR: foreach (tgt_tab[i]) tgt_tab[i] = 8'h00;
      OP_WRITE: tgt_tab[w.tile*MAXH + w.level] = w.data_in;
      OP_START: begin
        f_complete = 1'b1;
        f_corrupt = 1'b0;
        f_scanning = 1'b1;
        cur_tile = 0;
        cur_level = 0;
        rot_acc = 2'd0;
        led_now = LED_NONE;
      end
      OP_BYTE: begin
        if (f_scanning && cur_tile < TILES) begin
          if (cur_level >= MAXH) begin
            // Stack overflowed: only a zero byte makes it a full stack.
            if (w.data_in != 8'h00) begin
              f_complete = 1'b0;
              f_corrupt = 1'b1;
              close_tile(0, r);
            end else begin
              close_tile(MAXH, r);
            end
          end else begin
            idx = cur_tile*MAXH + cur_level;
            if (w.data_in == 8'h00) begin
              if (tgt_tab[idx] != 8'h00) f_complete = 1'b0;
              close_tile(cur_level, r);
            end else begin
              rot = w.data_in[1:0] + rot_acc;
              msk = ID_MASK | {6'd0, w.data_in[3:2]};
              absb = (w.data_in & ID_MASK) | {6'd0, rot};
              ok = (absb & msk) == (tgt_tab[idx] & msk);
              rot_acc = rot;
              if (!ok) f_complete = 1'b0;
              scan_tab[idx] = absb;
              led_now = led_for(ok);
              cur_level++;
            end
          end
        end
      end
      OP_RDBLK: r.read_value = scan_tab[w.tile*MAXH + w.level];
      OP_RDHGT: r.stack_height = hgt_tab[w.tile];
      default: ;
    endcase
    r.tx_byte = led_now;
    r.current_tile = cur_tile[4:0];
    r.complete = f_complete;
    r.corrupted = f_corrupt;
    expected_results.push_back(r);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) gap_len = 0;
    else if (p < 92) gap_len = $urandom_range(1, 3);
    else gap_len = $urandom_range(8, 40);
  endfunction

  function automatic in_word_t mk(logic [2:0] op, logic [3:0] t, logic [3:0] l,
                                  logic [7:0] d);
    in_word_t w;
    w.opcode = op;
    w.tile = t;
    w.level = l;
    w.data_in = d;
    mk = w;
  endfunction

  // Driver: offers the oldest pending word, with random gaps between words.
  int  send_gap;
  bit  send_hold;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
      send_gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // Holding the current word until it is taken.
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_result(in_ch.payload);
        n_sent++;
        void'(pending_words.pop_front());
      end
      if (in_ch.valid && in_ch.ready && gap_len() != 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= gap_len();
      end else if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!send_hold && pending_words.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.payload <= pending_words[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver: random stalls, plus one long requested hold-off.
  int recv_gap;
  always @(posedge clk) begin
    out_word_t e;
    out_word_t a;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
      stall_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        a = out_ch.payload;
        n_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result word %h", a);
          n_fail++;
        end else begin
          e = expected_results.pop_front();
          if (a.tx_byte !== e.tx_byte) begin
            $error("tx_byte exp %0d got %0d", e.tx_byte, a.tx_byte); n_fail++;
          end
          if (a.read_value !== e.read_value) begin
            $error("read_value exp %0d got %0d", e.read_value, a.read_value); n_fail++;
          end
          if (a.stack_height !== e.stack_height) begin
            $error("stack_height exp %0d got %0d", e.stack_height, a.stack_height);
            n_fail++;
          end
          if (a.tile_done !== e.tile_done) begin
            $error("tile_done exp %0d got %0d", e.tile_done, a.tile_done); n_fail++;
          end
          if (a.scan_done !== e.scan_done) begin
            $error("scan_done exp %0d got %0d", e.scan_done, a.scan_done); n_fail++;
          end
          if (a.current_tile !== e.current_tile) begin
            $error("current_tile exp %0d got %0d", e.current_tile, a.current_tile);
            n_fail++;
          end
          if (a.complete !== e.complete) begin
            $error("complete exp %0d got %0d", e.complete, a.complete); n_fail++;
          end
          if (a.corrupted !== e.corrupted) begin
            $error("corrupted exp %0d got %0d", e.corrupted, a.corrupted); n_fail++;
          end
        end
      end
      if (long_stall_req) begin
        long_stall_req <= 1'b0;
        stall_left <= 300;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_ch.ready) recv_gap <= gap_len();
      end
    end
  end

  // Watchdog on progress of either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      hang_count <= 0;
    else if (pending_words.size() > 0 || expected_results.size() > 0)
      hang_count <= hang_count + 1;
    if (hang_count >= HANG_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Waits until every queued word was taken and every result was checked.
  task automatic drain();
    while (pending_words.size() > 0 || expected_results.size() > 0 || in_ch.valid)
      @(posedge clk);
    // The block may be finishing internal work; give it a short margin.
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    mode_shadow = m;
  endtask

  // Queues a scan of every tile with random stack contents.
  task automatic queue_scan(input int kind);
    int h;
    int p;
    pending_words.push_back(mk(OP_START, 4'($urandom), 4'($urandom), 8'($urandom)));
    for (int t = 0; t < TILES; t++) begin
      p = $urandom_range(0, 99);
      h = (p < 10) ? MAXH : $urandom_range(0, 5);
      for (int l = 0; l < h; l++) begin
        // Usually a byte with a nonzero id and the level in its low bits.
        if (kind == 0 && $urandom_range(0, 3) != 0)
          pending_words.push_back(mk(OP_BYTE, 4'($urandom), 4'($urandom),
                                     {6'($urandom_range(1, 63)), 2'(l)}));
        else
          pending_words.push_back(mk(OP_BYTE, 4'($urandom), 4'($urandom),
                                     8'($urandom_range(1, 255))));
      end
      if (h == MAXH && $urandom_range(0, 1))
        pending_words.push_back(mk(OP_BYTE, 4'd0, 4'd0, 8'($urandom_range(1, 255))));
      else
        pending_words.push_back(mk(OP_BYTE, 4'($urandom), 4'($urandom), 8'h00));
      if ($urandom_range(0, 9) == 0)
        pending_words.push_back(mk(3'($urandom_range(4, 7)), 4'($urandom),
                                   4'($urandom), 8'($urandom)));
    end
  endtask

  initial begin
    logic [2:0] op;
    n_fail = 0;
    n_sent = 0;
    n_seen = 0;
    scans_done = 0;
    send_hold = 0;
    long_stall_req = 0;
    hang_count = 0;
    foreach (tgt_tab[i]) tgt_tab[i] = 8'h00;
    foreach (scan_tab[i]) scan_tab[i] = 8'h00;
    foreach (hgt_tab[i]) hgt_tab[i] = 5'd0;
    cur_tile = 0;
    cur_level = 0;
    rot_acc = 2'd0;
    led_now = LED_NONE;
    f_complete = 0;
    f_corrupt = 0;
    f_scanning = 0;
    mode_shadow = MODE_MATCH;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 2'd0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reads of reset state, byte while idle, extremes, no-ops.
    write_mode(MODE_MATCH);
    pending_words.push_back(mk(OP_RDBLK, 4'd15, 4'd15, 8'hFF));
    pending_words.push_back(mk(OP_RDHGT, 4'd0, 4'd0, 8'h00));
    pending_words.push_back(mk(OP_BYTE, 4'd0, 4'd0, 8'hA5));
    pending_words.push_back(mk(3'd6, 4'd15, 4'd15, 8'hFF));
    pending_words.push_back(mk(3'd7, 4'd0, 4'd0, 8'h00));
    pending_words.push_back(mk(OP_WRITE, 4'd0, 4'd0, 8'h05));
    pending_words.push_back(mk(OP_WRITE, 4'd15, 4'd15, 8'hFF));
    pending_words.push_back(mk(OP_WRITE, 4'd0, 4'd1, 8'h08));
    pending_words.push_back(mk(OP_START, 4'd0, 4'd0, 8'h00));
    pending_words.push_back(mk(OP_BYTE, 4'd0, 4'd0, 8'h05));  // match
    pending_words.push_back(mk(OP_BYTE, 4'd0, 4'd0, 8'h0B));  // rotation wraps
    pending_words.push_back(mk(OP_BYTE, 4'd0, 4'd0, 8'h00));  // tile ends
    // Second tile: full stack then a zero byte records the limit.
    for (int l = 0; l < MAXH; l++)
      pending_words.push_back(mk(OP_BYTE, 4'd0, 4'd0, 8'hFF));
    pending_words.push_back(mk(OP_BYTE, 4'd0, 4'd0, 8'h00));
    pending_words.push_back(mk(OP_RDBLK, 4'd1, 4'd15, 8'h00));
    pending_words.push_back(mk(OP_RDHGT, 4'd1, 4'd0, 8'h00));
    pending_words.push_back(mk(OP_CLEAR, 4'd0, 4'd0, 8'h00));
    drain();

    // Random phases; the first four walk every LED mode and the last matches.
    for (int ph = 0; ph < 8; ph++) begin
      write_mode((ph < 4) ? 2'(3 - ph) : (ph == 7) ? 2'd0 : 2'($urandom_range(0, 3)));
      if (ph == 2) begin
        // Long receiver hold-off while the sender keeps offering words.
        long_stall_req <= 1'b1;
      end
      for (int k = 0; k < 2; k++) begin
        if ($urandom_range(0, 2) == 0) begin
          for (int j = 0; j < 12; j++)
            pending_words.push_back(mk(OP_WRITE, 4'($urandom), 4'($urandom),
                                       8'($urandom)));
        end
        queue_scan($urandom_range(0, 1));
        for (int j = 0; j < 10; j++) begin
          op = 3'($urandom_range(0, 7));
          if (op == OP_CLEAR && $urandom_range(0, 3) != 0) op = OP_RDBLK;
          pending_words.push_back(mk(op, 4'($urandom), 4'($urandom), 8'($urandom)));
        end
      end
      if (ph == 4) begin
        // Sender pauses until every expected result has come back.
        send_hold = 1;
        while (expected_results.size() > 0 || in_ch.valid) @(posedge clk);
        send_hold = 0;
      end
      drain();
    end
    $display("covered %0d words, %0d results, %0d full scans, all LED modes",
             n_sent, n_seen, scans_done);
    if (n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
